/* rtl/core/lav_pkg.sv */
// shared types, constants and rounding helpers of the look-at view matrix pipeline
`default_nettype none
package lav_pkg;

  localparam int DW       = 32;
  localparam int AXW      = 18;
  localparam int QF       = 16;
  localparam int RW       = 30;
  localparam int NORM_POS = 29;
  localparam int SQW      = 2 * RW + 2;
  localparam int LW       = 31;
  localparam int QTW      = 17;
  localparam int NUMW     = RW + QF + 1;

  localparam logic signed [AXW-1:0] AX_ONE = 18'sd65536;
  localparam logic signed [63:0]    UNIT64 = 64'sd65536;
  localparam logic signed [63:0]    SMAX64 = 64'sd2147483647;
  localparam logic signed [63:0]    SMIN64 = -64'sd2147483648;

  typedef struct packed {
    logic [33:0]   rem;
    logic [LW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [LW-1:0]  rem;
    logic [QTW-1:0] q;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
    logic [33:0] r;
    logic [33:0] t;
    sq_t o;
    r = {s.rem[31:0], pair};
    t = {1'b0, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[LW-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[LW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t div_step(input dv_t s, input logic b, input logic [LW-1:0] d);
    logic [LW:0] r;
    logic [LW:0] t;
    dv_t o;
    r = {s.rem, b};
    t = {1'b0, d};
    if (r >= t) begin
      o.rem = LW'(r - t);
      o.q   = {s.q[QTW-2:0], 1'b1};
    end else begin
      o.rem = r[LW-1:0];
      o.q   = {s.q[QTW-2:0], 1'b0};
    end
    return o;
  endfunction

  // nearest, ties away from zero, to q16.16
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + 64'h8000) >> QF;
    return v[63] ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [AXW-1:0] clamp_unit(input logic signed [63:0] v);
    logic signed [AXW-1:0] o;
    if (v > UNIT64) begin
      o = AX_ONE;
    end else if (v < -UNIT64) begin
      o = -AX_ONE;
    end else begin
      o = $signed(v[AXW-1:0]);
    end
    return o;
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DW-1:0] o;
    if (v > SMAX64) begin
      o = $signed({1'b0, {(DW-1){1'b1}}});
    end else if (v < SMIN64) begin
      o = $signed({1'b1, {(DW-1){1'b0}}});
    end else begin
      o = $signed(v[DW-1:0]);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/lav_isqrt.sv */
// pipelined integer square root, two result bits per stage, one in the last stage
`default_nettype none
module lav_isqrt #(
  parameter int SW = 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [lav_pkg::SQW-1:0]  x,
  input  wire logic [SW-1:0]            side_i,
  output logic                          out_valid,
  output logic [lav_pkg::LW-1:0]        root,
  output logic [SW-1:0]                 side_o
);
  localparam int NST = (lav_pkg::LW + 1) / 2;
  localparam int XW  = lav_pkg::SQW;

  lav_pkg::sq_t     st_r   [NST];
  logic [XW-1:0]    x_r    [NST];
  logic [SW-1:0]    side_r [NST];
  logic [NST-1:0]   vld_r;

  for (genvar k = 0; k < NST; k++) begin : g_st
    lav_pkg::sq_t  a;
    lav_pkg::sq_t  b0;
    lav_pkg::sq_t  b;
    logic [XW-1:0] xi;
    logic [SW-1:0] si;
    logic          vi;
    if (k == 0) begin : g_first
      assign a  = '0;
      assign xi = x;
      assign si = side_i;
      assign vi = in_valid;
    end else begin : g_next
      assign a  = st_r[k-1];
      assign xi = x_r[k-1];
      assign si = side_r[k-1];
      assign vi = vld_r[k-1];
    end
    assign b0 = lav_pkg::sqrt_step(a, xi[XW-1-4*k -: 2]);
    if (2 * k + 1 < lav_pkg::LW) begin : g_two
      assign b = lav_pkg::sqrt_step(b0, xi[XW-3-4*k -: 2]);
    end else begin : g_one
      assign b = b0;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k]   <= b;
        x_r[k]    <= xi;
        side_r[k] <= si;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign root      = st_r[NST-1].root;
  assign side_o    = side_r[NST-1];

endmodule
`default_nettype wire

/* rtl/core/lav_div.sv */
// pipelined three-lane restoring divider with a shared divisor
`default_nettype none
module lav_div #(
  parameter int SW = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [lav_pkg::NUMW-1:0]  num [3],
  input  wire logic [lav_pkg::LW-1:0]    den,
  input  wire logic [SW-1:0]             side_i,
  output logic                           out_valid,
  output logic [lav_pkg::QTW-1:0]        q [3],
  output logic [SW-1:0]                  side_o
);
  localparam int QTW = lav_pkg::QTW;
  localparam int NW  = lav_pkg::NUMW;
  localparam int LW  = lav_pkg::LW;
  localparam int NST = (QTW + 1) / 2;

  lav_pkg::dv_t   st_r   [NST][3];
  logic [NW-1:0]  num_r  [NST][3];
  logic [LW-1:0]  den_r  [NST];
  logic [SW-1:0]  side_r [NST];
  logic [NST-1:0] vld_r;

  for (genvar k = 0; k < NST; k++) begin : g_st
    lav_pkg::dv_t  a  [3];
    lav_pkg::dv_t  b0 [3];
    lav_pkg::dv_t  b  [3];
    logic [NW-1:0] ni [3];
    logic [LW-1:0] di;
    logic [SW-1:0] si;
    logic          vi;
    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          a[i].rem = LW'(num[i][NW-1:QTW]);
          a[i].q   = '0;
          ni[i]    = num[i];
        end
      end
      assign di = den;
      assign si = side_i;
      assign vi = in_valid;
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          a[i]  = st_r[k-1][i];
          ni[i] = num_r[k-1][i];
        end
      end
      assign di = den_r[k-1];
      assign si = side_r[k-1];
      assign vi = vld_r[k-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        b0[i] = lav_pkg::div_step(a[i], ni[i][QTW-1-2*k], di);
      end
    end
    if (2 * k + 1 < QTW) begin : g_two
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          b[i] = lav_pkg::div_step(b0[i], ni[i][QTW-2-2*k], di);
        end
      end
    end else begin : g_one
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          b[i] = b0[i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          st_r[k][i]  <= b[i];
          num_r[k][i] <= ni[i];
        end
        den_r[k]  <= di;
        side_r[k] <= si;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign side_o    = side_r[NST-1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = st_r[NST-1][i].q;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lav_norm.sv */
// pipelined 3-vector normalizer to q16.16 unit length
`default_nettype none
module lav_norm #(
  parameter int IW = 33,
  parameter int SW = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [IW-1:0]          v_i [3],
  input  wire logic [SW-1:0]                 side_i,
  output logic                               out_valid,
  output logic signed [lav_pkg::AXW-1:0]     o [3],
  output logic [SW-1:0]                      side_o
);
  localparam int PW   = $clog2(IW);
  localparam int RW   = lav_pkg::RW;
  localparam int SQW  = lav_pkg::SQW;
  localparam int LW   = lav_pkg::LW;
  localparam int NW   = lav_pkg::NUMW;
  localparam int AXW  = lav_pkg::AXW;
  localparam int SQSW = 3 * RW + 4 + SW;
  localparam int DVSW = 4 + SW;

  // magnitudes
  logic [IW-1:0] m1_r [3];
  logic [2:0]    n1_r;
  logic [SW-1:0] s1_r;
  logic          v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= v_i[i][IW-1] ? IW'(-v_i[i]) : IW'(v_i[i]);
        n1_r[i] <= v_i[i][IW-1];
      end
      s1_r <= side_i;
    end
  end

  // leading one and shift amounts
  logic [IW-1:0] orw;
  logic [PW-1:0] pos;
  logic [PW-1:0] rs;
  logic [PW-1:0] ls;
  logic [IW-1:0] m2_r [3];
  logic [2:0]    n2_r;
  logic [PW-1:0] rs2_r;
  logic [PW-1:0] ls2_r;
  logic          z2_r;
  logic [SW-1:0] s2_r;
  logic          v2_r;

  always_comb begin
    orw = m1_r[0] | m1_r[1] | m1_r[2];
    pos = '0;
    for (int j = 0; j < IW; j++) begin
      if (orw[j]) begin
        pos = PW'(j);
      end
    end
    if (pos > PW'(lav_pkg::NORM_POS)) begin
      rs = pos - PW'(lav_pkg::NORM_POS);
      ls = '0;
    end else begin
      rs = '0;
      ls = PW'(lav_pkg::NORM_POS) - pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m2_r  <= m1_r;
      n2_r  <= n1_r;
      rs2_r <= rs;
      ls2_r <= ls;
      z2_r  <= (orw == '0);
      s2_r  <= s1_r;
    end
  end

  // scaled magnitudes
  logic [RW-1:0] r3_r [3];
  logic [2:0]    n3_r;
  logic          z3_r;
  logic [SW-1:0] s3_r;
  logic          v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r3_r[i] <= RW'((m2_r[i] >> rs2_r) << ls2_r);
      end
      n3_r <= n2_r;
      z3_r <= z2_r;
      s3_r <= s2_r;
    end
  end

  // squares
  logic [2*RW-1:0] sq4_r [3];
  logic [RW-1:0]   r4_r  [3];
  logic [2:0]      n4_r;
  logic            z4_r;
  logic [SW-1:0]   s4_r;
  logic            v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= (2*RW)'(r3_r[i]) * (2*RW)'(r3_r[i]);
      end
      r4_r <= r3_r;
      n4_r <= n3_r;
      z4_r <= z3_r;
      s4_r <= s3_r;
    end
  end

  // sum of squares
  logic [SQW-1:0] sum5_r;
  logic [RW-1:0]  r5_r [3];
  logic [2:0]     n5_r;
  logic           z5_r;
  logic [SW-1:0]  s5_r;
  logic           v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sum5_r <= SQW'(sq4_r[0]) + SQW'(sq4_r[1]) + SQW'(sq4_r[2]);
      r5_r   <= r4_r;
      n5_r   <= n4_r;
      z5_r   <= z4_r;
      s5_r   <= s4_r;
    end
  end

  // length
  logic [SQSW-1:0] sq_side_i;
  logic [SQSW-1:0] sq_side_o;
  logic            sq_valid;
  logic [LW-1:0]   len;
  logic [RW-1:0]   rq [3];
  logic [2:0]      nq;
  logic            zq;
  logic [SW-1:0]   sq_s;

  assign sq_side_i = {r5_r[0], r5_r[1], r5_r[2], n5_r, z5_r, s5_r};

  lav_isqrt #(.SW(SQSW)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .x         (sum5_r),
    .side_i    (sq_side_i),
    .out_valid (sq_valid),
    .root      (len),
    .side_o    (sq_side_o)
  );

  assign {rq[0], rq[1], rq[2], nq, zq, sq_s} = sq_side_o;

  // dividends with half-length rounding term
  logic [NW-1:0] num6_r [3];
  logic [LW-1:0] den6_r;
  logic [2:0]    n6_r;
  logic          z6_r;
  logic [SW-1:0] s6_r;
  logic          v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= sq_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num6_r[i] <= NW'({rq[i], {lav_pkg::QF{1'b0}}}) + NW'(len >> 1);
      end
      den6_r <= len;
      n6_r   <= nq;
      z6_r   <= zq;
      s6_r   <= sq_s;
    end
  end

  logic [DVSW-1:0]         dv_side_o;
  logic                    dv_valid;
  logic [lav_pkg::QTW-1:0] qt [3];
  logic [2:0]              nd;
  logic                    zd;
  logic [SW-1:0]           dv_s;

  lav_div #(.SW(DVSW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .num       (num6_r),
    .den       (den6_r),
    .side_i    ({n6_r, z6_r, s6_r}),
    .out_valid (dv_valid),
    .q         (qt),
    .side_o    (dv_side_o)
  );

  assign {nd, zd, dv_s} = dv_side_o;

  // sign and zero vector
  logic signed [AXW-1:0] o7_r [3];
  logic [SW-1:0]         s7_r;
  logic                  v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= dv_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zd) begin
          o7_r[i] <= '0;
        end else if (nd[i]) begin
          o7_r[i] <= -$signed(AXW'(qt[i]));
        end else begin
          o7_r[i] <= $signed(AXW'(qt[i]));
        end
      end
      s7_r <= dv_s;
    end
  end

  assign out_valid = v7_r;
  assign o         = o7_r;
  assign side_o    = s7_r;

endmodule
`default_nettype wire

/* rtl/core/look_at_view_matrix_unit.sv */
// top level of the look-at view matrix pipeline
//
// input word: eye, target and world up vectors, signed q16.16, on in_valid/in_ready.
// output word: right, upaxis and back axes (18-bit q16.16) and the saturated
// translation column, on out_valid/out_ready.
// the datapath is 73 register stages: one for eye - target, two normalizers of
// 32 stages each (square root and divider resolve two result bits per stage,
// one in their last stage), two for the cross product and six for the up axis,
// the dot products and the output register.
// throughput: one word per cycle while the pipe is not held by out_ready, items are independent.
// all stages advance together; when out_valid is high and out_ready low the
// whole pipe holds and in_ready drops, so nothing is dropped or repeated.
// reset clears every stage valid bit; data registers are not reset.
`default_nettype none
module look_at_view_matrix_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  in_eye_x,
  input  wire logic signed [31:0]  in_eye_y,
  input  wire logic signed [31:0]  in_eye_z,
  input  wire logic signed [31:0]  in_target_x,
  input  wire logic signed [31:0]  in_target_y,
  input  wire logic signed [31:0]  in_target_z,
  input  wire logic signed [31:0]  in_up_x,
  input  wire logic signed [31:0]  in_up_y,
  input  wire logic signed [31:0]  in_up_z,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [17:0]       out_right_x,
  output logic signed [17:0]       out_right_y,
  output logic signed [17:0]       out_right_z,
  output logic signed [17:0]       out_upaxis_x,
  output logic signed [17:0]       out_upaxis_y,
  output logic signed [17:0]       out_upaxis_z,
  output logic signed [17:0]       out_back_x,
  output logic signed [17:0]       out_back_y,
  output logic signed [17:0]       out_back_z,
  output logic signed [31:0]       out_trans_x,
  output logic signed [31:0]       out_trans_y,
  output logic signed [31:0]       out_trans_z
);
  localparam int DW  = lav_pkg::DW;
  localparam int AXW = lav_pkg::AXW;
  localparam int D1W = DW + 1;
  localparam int PCW = DW + AXW;
  localparam int CW  = PCW + 1;
  localparam int PAW = 2 * AXW;
  localparam int UAW = PAW + 1;
  localparam int DTW = PCW + 2;
  localparam int S1W = 6 * DW;
  localparam int S2W = 3 * DW + 3 * AXW;

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic signed [DW-1:0] eye_i [3];
  logic signed [DW-1:0] tgt_i [3];
  logic signed [DW-1:0] up_i  [3];

  assign eye_i = '{in_eye_x, in_eye_y, in_eye_z};
  assign tgt_i = '{in_target_x, in_target_y, in_target_z};
  assign up_i  = '{in_up_x, in_up_y, in_up_z};

  // view direction
  logic signed [D1W-1:0] da_r  [3];
  logic signed [DW-1:0]  eya_r [3];
  logic signed [DW-1:0]  upa_r [3];
  logic                  va_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid && in_ready;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        da_r[i] <= $signed({eye_i[i][DW-1], eye_i[i]}) - $signed({tgt_i[i][DW-1], tgt_i[i]});
      end
      eya_r <= eye_i;
      upa_r <= up_i;
    end
  end

  logic                  n1_valid;
  logic signed [AXW-1:0] bk1 [3];
  logic [S1W-1:0]        n1_side;
  logic signed [DW-1:0]  eye1 [3];
  logic signed [DW-1:0]  up1  [3];

  lav_norm #(.IW(D1W), .SW(S1W)) u_norm_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (va_r),
    .v_i       (da_r),
    .side_i    ({eya_r[0], eya_r[1], eya_r[2], upa_r[0], upa_r[1], upa_r[2]}),
    .out_valid (n1_valid),
    .o         (bk1),
    .side_o    (n1_side)
  );

  assign {eye1[0], eye1[1], eye1[2], up1[0], up1[1], up1[2]} = n1_side;

  // cross(up, back)
  logic signed [PCW-1:0] pb_r  [6];
  logic signed [AXW-1:0] bkb_r [3];
  logic signed [DW-1:0]  eyb_r [3];
  logic                  vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= n1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pb_r[0] <= up1[1] * bk1[2];
      pb_r[1] <= up1[2] * bk1[1];
      pb_r[2] <= up1[2] * bk1[0];
      pb_r[3] <= up1[0] * bk1[2];
      pb_r[4] <= up1[0] * bk1[1];
      pb_r[5] <= up1[1] * bk1[0];
      bkb_r   <= bk1;
      eyb_r   <= eye1;
    end
  end

  logic signed [CW-1:0]  cc_r  [3];
  logic signed [AXW-1:0] bkc_r [3];
  logic signed [DW-1:0]  eyc_r [3];
  logic                  vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cc_r[i] <= CW'(pb_r[2*i]) - CW'(pb_r[2*i+1]);
      end
      bkc_r <= bkb_r;
      eyc_r <= eyb_r;
    end
  end

  logic                  n2_valid;
  logic signed [AXW-1:0] rt2 [3];
  logic [S2W-1:0]        n2_side;
  logic signed [DW-1:0]  eye2 [3];
  logic signed [AXW-1:0] bk2  [3];

  lav_norm #(.IW(CW), .SW(S2W)) u_norm_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vc_r),
    .v_i       (cc_r),
    .side_i    ({eyc_r[0], eyc_r[1], eyc_r[2], bkc_r[0], bkc_r[1], bkc_r[2]}),
    .out_valid (n2_valid),
    .o         (rt2),
    .side_o    (n2_side)
  );

  assign {eye2[0], eye2[1], eye2[2], bk2[0], bk2[1], bk2[2]} = n2_side;

  // up axis products and right/back dot products
  logic signed [PAW-1:0] pu_r  [6];
  logic signed [PCW-1:0] prd_r [3];
  logic signed [PCW-1:0] pbd_r [3];
  logic signed [AXW-1:0] rtd_r [3];
  logic signed [AXW-1:0] bkd_r [3];
  logic signed [DW-1:0]  eyd_r [3];
  logic                  vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= n2_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pu_r[0] <= bk2[1] * rt2[2];
      pu_r[1] <= bk2[2] * rt2[1];
      pu_r[2] <= bk2[2] * rt2[0];
      pu_r[3] <= bk2[0] * rt2[2];
      pu_r[4] <= bk2[0] * rt2[1];
      pu_r[5] <= bk2[1] * rt2[0];
      for (int i = 0; i < 3; i++) begin
        prd_r[i] <= rt2[i] * eye2[i];
        pbd_r[i] <= bk2[i] * eye2[i];
      end
      rtd_r <= rt2;
      bkd_r <= bk2;
      eyd_r <= eye2;
    end
  end

  logic signed [UAW-1:0] uae_r [3];
  logic signed [DTW-1:0] dre_r;
  logic signed [DTW-1:0] dbe_r;
  logic signed [AXW-1:0] rte_r [3];
  logic signed [AXW-1:0] bke_r [3];
  logic signed [DW-1:0]  eye_e_r [3];
  logic                  ve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vd_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uae_r[i] <= UAW'(pu_r[2*i]) - UAW'(pu_r[2*i+1]);
      end
      dre_r   <= DTW'(prd_r[0]) + DTW'(prd_r[1]) + DTW'(prd_r[2]);
      dbe_r   <= DTW'(pbd_r[0]) + DTW'(pbd_r[1]) + DTW'(pbd_r[2]);
      rte_r   <= rtd_r;
      bke_r   <= bkd_r;
      eye_e_r <= eyd_r;
    end
  end

  logic signed [AXW-1:0] uaf_r [3];
  logic signed [DW-1:0]  trxf_r;
  logic signed [DW-1:0]  trzf_r;
  logic signed [AXW-1:0] rtf_r [3];
  logic signed [AXW-1:0] bkf_r [3];
  logic signed [DW-1:0]  eyf_r [3];
  logic                  vf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uaf_r[i] <= lav_pkg::clamp_unit(lav_pkg::rnd16(64'(uae_r[i])));
      end
      trxf_r <= lav_pkg::sat32(-lav_pkg::rnd16(64'(dre_r)));
      trzf_r <= lav_pkg::sat32(-lav_pkg::rnd16(64'(dbe_r)));
      rtf_r  <= rte_r;
      bkf_r  <= bke_r;
      eyf_r  <= eye_e_r;
    end
  end

  // up axis dot product
  logic signed [PCW-1:0] pug_r [3];
  logic signed [AXW-1:0] uag_r [3];
  logic signed [DW-1:0]  trxg_r;
  logic signed [DW-1:0]  trzg_r;
  logic signed [AXW-1:0] rtg_r [3];
  logic signed [AXW-1:0] bkg_r [3];
  logic                  vg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= vf_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pug_r[i] <= uaf_r[i] * eyf_r[i];
      end
      uag_r  <= uaf_r;
      trxg_r <= trxf_r;
      trzg_r <= trzf_r;
      rtg_r  <= rtf_r;
      bkg_r  <= bkf_r;
    end
  end

  logic signed [DTW-1:0] duh_r;
  logic signed [AXW-1:0] uah_r [3];
  logic signed [DW-1:0]  trxh_r;
  logic signed [DW-1:0]  trzh_r;
  logic signed [AXW-1:0] rth_r [3];
  logic signed [AXW-1:0] bkh_r [3];
  logic                  vh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (en) begin
      vh_r <= vg_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      duh_r  <= DTW'(pug_r[0]) + DTW'(pug_r[1]) + DTW'(pug_r[2]);
      uah_r  <= uag_r;
      trxh_r <= trxg_r;
      trzh_r <= trzg_r;
      rth_r  <= rtg_r;
      bkh_r  <= bkg_r;
    end
  end

  // output register
  logic signed [AXW-1:0] rto_r [3];
  logic signed [AXW-1:0] uao_r [3];
  logic signed [AXW-1:0] bko_r [3];
  logic signed [DW-1:0]  tro_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vh_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rto_r    <= rth_r;
      uao_r    <= uah_r;
      bko_r    <= bkh_r;
      tro_r[0] <= trxh_r;
      tro_r[1] <= lav_pkg::sat32(-lav_pkg::rnd16(64'(duh_r)));
      tro_r[2] <= trzh_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_right_x  = rto_r[0];
  assign out_right_y  = rto_r[1];
  assign out_right_z  = rto_r[2];
  assign out_upaxis_x = uao_r[0];
  assign out_upaxis_y = uao_r[1];
  assign out_upaxis_z = uao_r[2];
  assign out_back_x   = bko_r[0];
  assign out_back_y   = bko_r[1];
  assign out_back_z   = bko_r[2];
  assign out_trans_x  = tro_r[0];
  assign out_trans_y  = tro_r[1];
  assign out_trans_z  = tro_r[2];

  // a zero view direction gives a zero matrix; checked on right, upaxis x and translation x and z
  a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_back_x == '0 && out_back_y == '0 && out_back_z == '0
    |-> out_right_x == '0 && out_right_y == '0 && out_right_z == '0
        && out_upaxis_x == '0 && out_trans_x == '0 && out_trans_z == '0)
    else $error("nonzero matrix for zero view direction");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_back_x <= lav_pkg::AX_ONE && out_back_x >= -lav_pkg::AX_ONE
      && out_right_y <= lav_pkg::AX_ONE && out_right_y >= -lav_pkg::AX_ONE)
    else $error("axis component out of unit range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
